@@ rtl/sacl_pkg.sv @@
// Package for the set-associative cache: default geometry, register indexes,
// operation and mode codes, controller states and the lookup result record.
// No dependencies.
package sacl_pkg;

    localparam int DEF_ADDR_BITS        = 16;
    localparam int DEF_MAX_WAYS         = 8;
    localparam int DEF_MAX_SET_BITS     = 6;
    localparam int DEF_MAX_BLOCK_BYTES  = 64;
    localparam int DEF_MAX_ACCESS_BYTES = 8;

    localparam int DATA_W      = 64;
    localparam int NBYTES_W    = 4;
    localparam int WAYS_CNT_W  = 5;
    localparam int LK_WAY_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int MIN_BLOCK_LOG2 = 3;

    localparam logic       RST_WRITE_BACK  = 1'b1;
    localparam logic [3:0] RST_WAYS        = 4'd4;
    localparam logic [2:0] RST_BLOCK_LOG2  = 3'd5;
    localparam logic [2:0] RST_SET_LOG2    = 3'd4;

    localparam logic MODE_WT = 1'b0;
    localparam logic MODE_WB = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRITE_BACK = 2'd0,
        CFG_WAYS       = 2'd1,
        CFG_BLOCK_LOG2 = 2'd2,
        CFG_SET_LOG2   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_META,
        S_LOOK,
        S_WB,
        S_FILL,
        S_RD0,
        S_RD1,
        S_WR0,
        S_WR1
    } t_state;

    typedef struct packed {
        logic                hit;
        logic                use_way;
        logic                alloc;
        logic                need_wb;
        logic [LK_WAY_W-1:0] way;
    } t_lk;

endpackage

@@ rtl/sacl_if.sv @@
// Handshake interfaces of the cache: access requests, results and register writes.
// Depends on sacl_pkg.
interface sacl_in_if import sacl_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [ADDR_BITS-1:0] address;
    logic [NBYTES_W-1:0]  access_bytes;
    logic [DATA_W-1:0]    store_data;

    modport source (output valid, operation, address, access_bytes, store_data, input ready);
    modport sink   (input valid, operation, address, access_bytes, store_data, output ready);
endinterface

interface sacl_out_if import sacl_pkg::*;;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DATA_W-1:0] load_data;

    modport source (output valid, hit, load_data, input ready);
    modport sink   (input valid, hit, load_data, output ready);
endinterface

interface sacl_cfg_if import sacl_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sacl_lookup.sv @@
// Set lookup: way scan, LRU victim choice, allocation decision and the
// updated tag, state and rank fields of the set. Depends on sacl_pkg.
module sacl_lookup import sacl_pkg::*; #(
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    parameter int TAG_W    = DEF_ADDR_BITS - 3,
    parameter int WAY_W    = 3
) (
    input  logic [WAYS_CNT_W-1:0]           i_ways,
    input  logic                            i_store,
    input  logic                            i_wb_mode,
    input  logic [TAG_W-1:0]                i_tag,
    input  logic [MAX_WAYS-1:0]             i_valid,
    input  logic [MAX_WAYS-1:0]             i_dirty,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]  i_line_tag,
    input  logic [MAX_WAYS-1:0][WAY_W-1:0]  i_rank,
    output t_lk                             o_lk,
    output logic [MAX_WAYS-1:0]             o_valid,
    output logic [MAX_WAYS-1:0]             o_dirty,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]  o_line_tag,
    output logic [MAX_WAYS-1:0][WAY_W-1:0]  o_rank,
    output logic [TAG_W-1:0]                o_victim_tag
);

    logic             found, hit, free, alloc, use_way;
    logic [WAY_W-1:0] hit_way, free_way, victim, way, victim_rank, way_rank;

    // The scan stops at the first free way or the first matching tag.
    always_comb begin
        found    = 1'b0;
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!found && WAYS_CNT_W'(i) < i_ways) begin
                if (!i_valid[i]) begin
                    free     = 1'b1;
                    free_way = WAY_W'(i);
                    found    = 1'b1;
                end else if (i_line_tag[i] == i_tag) begin
                    hit      = 1'b1;
                    hit_way  = WAY_W'(i);
                    found    = 1'b1;
                end
            end
        end
    end

    always_comb begin
        victim      = '0;
        victim_rank = i_rank[0];
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (WAYS_CNT_W'(i) < i_ways && i_rank[i] > victim_rank) begin
                victim      = WAY_W'(i);
                victim_rank = i_rank[i];
            end
        end
    end

    assign alloc    = !hit && (!i_store || i_wb_mode);
    assign use_way  = hit || alloc;
    assign way      = hit ? hit_way : (free ? free_way : victim);
    assign way_rank = i_rank[way];

    always_comb begin
        o_valid    = i_valid;
        o_dirty    = i_dirty;
        o_line_tag = i_line_tag;
        o_rank     = i_rank;
        if (alloc) begin
            o_valid[way]    = 1'b1;
            o_dirty[way]    = 1'b0;
            o_line_tag[way] = i_tag;
        end
        if (use_way) begin
            if (i_store && i_wb_mode) begin
                o_dirty[way] = 1'b1;
            end
            for (int k = 0; k < MAX_WAYS; k++) begin
                if (i_rank[k] < way_rank) begin
                    o_rank[k] = i_rank[k] + 1'b1;
                end
            end
            o_rank[way] = '0;
        end
    end

    assign o_lk.hit     = hit;
    assign o_lk.use_way = use_way;
    assign o_lk.alloc   = alloc;
    assign o_lk.need_wb = alloc && !free && i_valid[victim] && i_dirty[victim];
    assign o_lk.way     = LK_WAY_W'(way);
    assign o_victim_tag = i_line_tag[victim];

endmodule

@@ rtl/set_assoc_cache_lru_wb_wt.sv @@
// Top level of the set-associative cache with true-LRU replacement in front of
// a backing memory. Depends on sacl_pkg, sacl_if and sacl_lookup.
//
//  Channel | Dir | Carries                                     | Transfer when
//  i_in    | in  | operation, address, access_bytes, store_data | valid && ready
//  o_out   | out | hit, load_data                               | valid && ready
//  i_cfg   | in  | index, data (register write)                 | valid && ready
//
// A hit or a write-through store miss runs the META, LOOK, RD0, RD1, WR0 and
// WR1 steps; a miss that allocates adds a FILL step that copies the block
// from the backing memory into the line store one eight-byte word at a time,
// preceded for a dirty victim by a WB step that writes it back. After reset
// a clearing pass over the 2^(ADDR_BITS-3) words of the backing memory (8192
// by default), or over the sets if they are more, zeroes the backing memory and
// the set records; no request is taken then, register writes are. The result
// sits in an output register, so a new request is taken while it waits; a request
// that finishes while the previous result is still held stalls in its last step.
module set_assoc_cache_lru_wb_wt import sacl_pkg::*; #(
    parameter int ADDR_BITS        = DEF_ADDR_BITS,
    parameter int MAX_WAYS         = DEF_MAX_WAYS,
    parameter int MAX_SET_BITS     = DEF_MAX_SET_BITS,
    parameter int MAX_BLOCK_BYTES  = DEF_MAX_BLOCK_BYTES,
    parameter int MAX_ACCESS_BYTES = DEF_MAX_ACCESS_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sacl_in_if.sink         i_in,
    sacl_out_if.source      o_out,
    sacl_cfg_if.sink        i_cfg
);

    // Geometry derived from the parameters.
    localparam int AW      = ADDR_BITS;
    localparam int TAG_W   = AW - MIN_BLOCK_LOG2;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int BMAX    = $clog2(MAX_BLOCK_BYTES + 1) - 1;
    localparam int WORD_W  = (BMAX > MIN_BLOCK_LOG2) ? BMAX - MIN_BLOCK_LOG2 : 1;
    localparam int BMW     = AW - MIN_BLOCK_LOG2;
    localparam int LINE_AW = SET_W + WAY_W + WORD_W;
    localparam int FLD_W   = 2 + TAG_W + WAY_W;
    localparam int META_W  = MAX_WAYS * FLD_W;
    localparam int BMEM_N  = 1 << BMW;
    localparam int META_N  = 1 << SET_W;
    localparam int LINE_N  = 1 << LINE_AW;
    localparam int CLR_N   = (BMEM_N > META_N) ? BMEM_N : META_N;
    localparam int CLR_W   = $clog2(CLR_N + 1);
    localparam int WIDE_W  = TAG_W + BMAX + MAX_SET_BITS;
    localparam int SH_W    = 5;
    localparam int K_W     = WORD_W + 1;

    // Configuration registers.
    logic       r_wbm;
    logic [3:0] r_ways_cfg;
    logic [2:0] r_blk_cfg;
    logic [2:0] r_set_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbm      <= RST_WRITE_BACK;
            r_ways_cfg <= RST_WAYS;
            r_blk_cfg  <= RST_BLOCK_LOG2;
            r_set_cfg  <= RST_SET_LOG2;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WRITE_BACK: r_wbm      <= i_cfg.data[0];
                CFG_WAYS:       r_ways_cfg <= i_cfg.data;
                CFG_BLOCK_LOG2: r_blk_cfg  <= i_cfg.data[2:0];
                CFG_SET_LOG2:   r_set_cfg  <= i_cfg.data[2:0];
                default:        ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Register values out of range are saturated to the legal geometry.
    logic [WAYS_CNT_W-1:0] c_ways;
    logic [2:0]            c_b;
    logic [3:0]            c_s;

    assign c_ways = (r_ways_cfg == '0) ? WAYS_CNT_W'(1) :
                    ((WAYS_CNT_W'(r_ways_cfg) > WAYS_CNT_W'(MAX_WAYS)) ?
                     WAYS_CNT_W'(MAX_WAYS) : WAYS_CNT_W'(r_ways_cfg));
    assign c_b    = (r_blk_cfg < 3'(MIN_BLOCK_LOG2)) ? 3'(MIN_BLOCK_LOG2) :
                    ((r_blk_cfg > 3'(BMAX)) ? 3'(BMAX) : r_blk_cfg);
    assign c_s    = ({1'b0, r_set_cfg} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) :
                    {1'b0, r_set_cfg};

    // Split of the incoming address under the current geometry.
    logic [AW-1:0]     a_set_full;
    logic [SET_W-1:0]  a_set;
    logic [TAG_W-1:0]  a_tag;
    logic [K_W-1:0]    a_words, a_wmask;
    logic [BMW-1:0]    a_word_addr, a_base;
    logic [WORD_W-1:0] a_w0, a_w1;
    logic [NBYTES_W-1:0] a_n;

    assign a_set_full  = (i_in.address >> c_b) & ~({AW{1'b1}} << c_s);
    assign a_set       = a_set_full[SET_W-1:0];
    assign a_tag       = TAG_W'(i_in.address >> (SH_W'(c_b) + SH_W'(c_s)));
    assign a_words     = K_W'(1) << (c_b - 3'(MIN_BLOCK_LOG2));
    assign a_wmask     = a_words - K_W'(1);
    assign a_word_addr = i_in.address[AW-1:MIN_BLOCK_LOG2];
    assign a_w0        = WORD_W'(a_word_addr & BMW'(a_wmask));
    assign a_w1        = WORD_W'((K_W'(a_w0) + K_W'(1)) & a_wmask);
    assign a_base      = a_word_addr & ~BMW'(a_wmask);
    assign a_n         = (i_in.access_bytes > NBYTES_W'(MAX_ACCESS_BYTES)) ?
                         NBYTES_W'(MAX_ACCESS_BYTES) : i_in.access_bytes;

    // Controller state and the fields of the request being served.
    t_state              r_state, n_state;
    logic [CLR_W-1:0]    r_clr;
    logic                r_op;
    logic [NBYTES_W-1:0] r_n;
    logic [DATA_W-1:0]   r_sdata;
    logic [TAG_W-1:0]    r_tag;
    logic [SET_W-1:0]    r_set;
    logic [2:0]          r_b;
    logic [3:0]          r_s;
    logic [2:0]          r_off7;
    logic [WORD_W-1:0]   r_w0, r_w1;
    logic [BMW-1:0]      r_base, r_wb_word;
    logic [K_W-1:0]      r_words, r_k;
    t_lk                 r_lk;
    logic [DATA_W-1:0]   r_w0_data;
    logic                r_res_hit;
    logic [DATA_W-1:0]   r_res_data;
    logic                r_out_valid, r_out_hit;
    logic [DATA_W-1:0]   r_out_data;

    // Memories and their ports.
    logic [META_W-1:0]     r_meta [META_N];
    logic [DATA_W-1:0]     r_line [LINE_N];
    logic [DATA_W-1:0]     r_bmem [BMEM_N];
    logic [META_W-1:0]     meta_q, meta_wdata, meta_clear, lk_meta;
    logic                  meta_we;
    logic [SET_W-1:0]      meta_waddr;
    logic [DATA_W-1:0]     line_q, line_wdata, bmem_q, bmem_wdata;
    logic                  line_we, bmem_we;
    logic [LINE_AW-1:0]    line_raddr, line_waddr;
    logic [BMW-1:0]        bmem_raddr, bmem_waddr;
    logic [7:0]            line_be, bmem_be;

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta[meta_waddr] <= meta_wdata;
        end
        meta_q <= r_meta[r_set];
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) begin
            if (line_we && line_be[j]) begin
                r_line[line_waddr][8*j +: 8] <= line_wdata[8*j +: 8];
            end
        end
        line_q <= r_line[line_raddr];
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) begin
            if (bmem_we && bmem_be[j]) begin
                r_bmem[bmem_waddr][8*j +: 8] <= bmem_wdata[8*j +: 8];
            end
        end
        bmem_q <= r_bmem[bmem_raddr];
    end

    // Set record: per way a valid bit, a dirty bit, the tag and the LRU rank.
    logic [MAX_WAYS-1:0]            m_valid, m_dirty, u_valid, u_dirty;
    logic [MAX_WAYS-1:0][TAG_W-1:0] m_tag, u_tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0] m_rank, u_rank;
    logic [TAG_W-1:0]               lk_victim_tag;
    t_lk                            lk;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            m_rank[w]  = meta_q[w*FLD_W +: WAY_W];
            m_tag[w]   = meta_q[w*FLD_W + WAY_W +: TAG_W];
            m_dirty[w] = meta_q[w*FLD_W + WAY_W + TAG_W];
            m_valid[w] = meta_q[w*FLD_W + WAY_W + TAG_W + 1];
            lk_meta[w*FLD_W +: FLD_W]    = {u_valid[w], u_dirty[w], u_tag[w], u_rank[w]};
            meta_clear[w*FLD_W +: FLD_W] = {2'b00, {TAG_W{1'b0}}, WAY_W'(w)};
        end
    end

    sacl_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .WAY_W    (WAY_W)
    ) u_lookup (
        .i_ways       (c_ways),
        .i_store      (r_op == OP_STORE),
        .i_wb_mode    (r_wbm == MODE_WB),
        .i_tag        (r_tag),
        .i_valid      (m_valid),
        .i_dirty      (m_dirty),
        .i_line_tag   (m_tag),
        .i_rank       (m_rank),
        .o_lk         (lk),
        .o_valid      (u_valid),
        .o_dirty      (u_dirty),
        .o_line_tag   (u_tag),
        .o_rank       (u_rank),
        .o_victim_tag (lk_victim_tag)
    );

    // Address of the victim block, rebuilt from its tag and the set.
    logic [WIDE_W-1:0] wb_wide;
    assign wb_wide = (WIDE_W'(lk_victim_tag) << (SH_W'(r_b) + SH_W'(r_s)))
                   | (WIDE_W'(r_set) << r_b);

    // Byte lanes of the access. The two words read form a sixteen-byte window,
    // byte p of which is the p-th byte after the start of the first word.
    logic [2*DATA_W-1:0] win;
    logic [DATA_W-1:0]   ldata, st0, st1;
    logic [7:0]          m0, m1;
    logic [3:0]          p, d0, d1, e0, e1;
    logic [K_W-1:0]      k_prev;
    logic                is_store;

    assign win      = {line_q, r_w0_data};
    assign k_prev   = r_k - K_W'(1);
    assign is_store = (r_op == OP_STORE);

    always_comb begin
        ldata = '0;
        st0   = '0;
        st1   = '0;
        m0    = '0;
        m1    = '0;
        p     = '0;
        d0    = '0;
        d1    = '0;
        e0    = '0;
        e1    = '0;
        for (int k = 0; k < 8; k++) begin
            p = {1'b0, r_off7} + r_n - 4'd1 - 4'(k);
            if (4'(k) < r_n) begin
                ldata[8*k +: 8] = win[{p, 3'b000} +: 8];
            end
        end
        for (int j = 0; j < 8; j++) begin
            d0 = 4'(j) - {1'b0, r_off7};
            d1 = 4'(j + 8) - {1'b0, r_off7};
            e0 = r_n - 4'd1 - d0;
            e1 = r_n - 4'd1 - d1;
            m0[j] = (3'(j) >= r_off7) && (d0 < r_n);
            m1[j] = (d1 < r_n);
            st0[8*j +: 8] = r_sdata[{e0[2:0], 3'b000} +: 8];
            st1[8*j +: 8] = r_sdata[{e1[2:0], 3'b000} +: 8];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == CLR_W'(CLR_N - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_in.valid) n_state = S_META;
            S_META:  n_state = S_LOOK;
            S_LOOK: begin
                if (lk.need_wb) begin
                    n_state = S_WB;
                end else if (lk.alloc) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_WB:    if (r_k == r_words) n_state = S_FILL;
            S_FILL:  if (r_k == r_words) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_WR0;
            S_WR0:   n_state = S_WR1;
            S_WR1:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port controls.
    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = r_set;
        meta_wdata = lk_meta;
        line_raddr = {r_set, r_lk.way[WAY_W-1:0], r_w0};
        line_we    = 1'b0;
        line_waddr = {r_set, r_lk.way[WAY_W-1:0], r_w0};
        line_wdata = st0;
        line_be    = m0;
        bmem_raddr = r_base | BMW'(r_k[WORD_W-1:0]);
        bmem_we    = 1'b0;
        bmem_waddr = r_base | BMW'(r_w0);
        bmem_wdata = st0;
        bmem_be    = m0;
        case (r_state)
            S_CLEAR: begin
                bmem_we    = (r_clr < CLR_W'(BMEM_N));
                bmem_waddr = r_clr[BMW-1:0];
                bmem_wdata = '0;
                bmem_be    = '1;
                meta_we    = (r_clr < CLR_W'(META_N));
                meta_waddr = r_clr[SET_W-1:0];
                meta_wdata = meta_clear;
            end
            S_LOOK: meta_we = 1'b1;
            S_WB: begin
                line_raddr = {r_set, r_lk.way[WAY_W-1:0], r_k[WORD_W-1:0]};
                bmem_we    = (r_k != '0);
                bmem_waddr = r_wb_word | BMW'(k_prev[WORD_W-1:0]);
                bmem_wdata = line_q;
                bmem_be    = '1;
            end
            S_FILL: begin
                line_we    = (r_k != '0);
                line_waddr = {r_set, r_lk.way[WAY_W-1:0], k_prev[WORD_W-1:0]};
                line_wdata = bmem_q;
                line_be    = '1;
            end
            S_RD0: line_raddr = {r_set, r_lk.way[WAY_W-1:0], r_w0};
            S_RD1: line_raddr = {r_set, r_lk.way[WAY_W-1:0], r_w1};
            S_WR0: begin
                line_we = r_lk.use_way && is_store;
                bmem_we = is_store && (r_wbm == MODE_WT);
            end
            S_WR1: begin
                line_we    = r_lk.use_way && is_store;
                line_waddr = {r_set, r_lk.way[WAY_W-1:0], r_w1};
                line_wdata = st1;
                line_be    = m1;
                bmem_we    = is_store && (r_wbm == MODE_WT);
                bmem_waddr = r_base | BMW'(r_w1);
                bmem_wdata = st1;
                bmem_be    = m1;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (r_state == S_LOOK || n_state == S_FILL && r_state == S_WB ||
                r_k == r_words) begin
                r_k <= '0;
            end else if (r_state == S_WB || r_state == S_FILL) begin
                r_k <= r_k + K_W'(1);
            end
            if (r_state == S_WR1 && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op      <= i_in.operation;
            r_n       <= a_n;
            r_sdata   <= i_in.store_data;
            r_tag     <= a_tag;
            r_set     <= a_set;
            r_b       <= c_b;
            r_s       <= c_s;
            r_off7    <= i_in.address[2:0];
            r_w0      <= a_w0;
            r_w1      <= a_w1;
            r_base    <= a_base;
            r_words   <= a_words;
        end
        if (r_state == S_LOOK) begin
            r_lk      <= lk;
            r_wb_word <= wb_wide[AW-1:MIN_BLOCK_LOG2];
        end
        if (r_state == S_RD1) begin
            r_w0_data <= line_q;
        end
        if (r_state == S_WR0) begin
            r_res_hit  <= r_lk.hit;
            r_res_data <= is_store ? '0 : ldata;
        end
        if (r_state == S_WR1 && (!r_out_valid || o_out.ready)) begin
            r_out_hit  <= r_res_hit;
            r_out_data <= r_res_data;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.hit       = r_out_hit;
    assign o_out.load_data = r_out_data;

    // A hit never evicts, and the chosen way always lies among the ways in use.
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && lk.hit) |-> !lk.need_wb)
        else $error("hit asks for a write-back");

    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && lk.use_way) |-> (WAYS_CNT_W'(lk.way) < c_ways))
        else $error("selected way outside the ways in use");

    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB || r_state == S_FILL) |-> (r_k <= r_words))
        else $error("block word counter overran the block");

    a_result_after_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WR1))
        else $error("result appeared without a finished access");

endmodule

@@ tb/tb_set_assoc_cache_lru_wb_wt.sv @@
// Self-checking testbench for the set-associative LRU cache in front of its backing memory.
// Depends on sacl_pkg, the sacl_if interfaces and the set_assoc_cache_lru_wb_wt RTL.
// A behavioural cache model predicts hit and load data for each accepted request.
module tb_set_assoc_cache_lru_wb_wt;
    import sacl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    sacl_in_if  in_if ();
    sacl_out_if out_if ();
    sacl_cfg_if cfg_if ();

    set_assoc_cache_lru_wb_wt u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // The clock runs at 125 MHz.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cache model. It mirrors the block's state: line records per set and
    // way, the line bytes, and the 64 KiB backing memory cleared at reset.
    // ------------------------------------------------------------------
    logic [7:0] mem_bytes [65536];
    logic [7:0] line_data [64][8][64];
    logic       line_vld  [64][8];
    logic       line_drt  [64][8];
    int         line_tg   [64][8];
    int         lru_pos   [64][8];

    logic       mode_wb;
    logic [3:0] cfg_ways;
    logic [2:0] cfg_blk_log2;
    logic [2:0] cfg_set_log2;

    // Expected results, oldest first.
    typedef struct {
        logic        hit;
        logic [63:0] load_data;
    } t_result;

    t_result expected_q [$];

    int errors;
    int n_accepted;
    int n_checked;
    int n_hits;
    int n_stores;

    logic sink_idle_en;
    logic sink_hold_req;
    logic src_idle_en;

    function automatic void cache_model_reset();
        for (int a = 0; a < 65536; a++) mem_bytes[a] = 8'h00;
        for (int s = 0; s < 64; s++) begin
            for (int w = 0; w < 8; w++) begin
                line_vld[s][w] = 1'b0;
                line_drt[s][w] = 1'b0;
                line_tg[s][w]  = 0;
                lru_pos[s][w]  = w;
                for (int k = 0; k < 64; k++) line_data[s][w][k] = 8'h00;
            end
        end
        mode_wb      = RST_WRITE_BACK;
        cfg_ways     = RST_WAYS;
        cfg_blk_log2 = RST_BLOCK_LOG2;
        cfg_set_log2 = RST_SET_LOG2;
    endfunction

    // Works out hit and load data for one access and updates the model.
    function automatic void predict_access(input logic op, input logic [15:0] addr,
                                           input logic [3:0] nb, input logic [63:0] sd,
                                           output logic hit, output logic [63:0] ld);
        int n, ways, b, s, bsize, off, set, tag, base;
        int free_way, hit_way, way, vic, o, r;
        int wb_base;
        logic [7:0] byte_v;
        n     = (nb > 8) ? 8 : int'(nb);
        ways  = (cfg_ways < 1) ? 1 : ((cfg_ways > 8) ? 8 : int'(cfg_ways));
        b     = (cfg_blk_log2 < 3) ? 3 : ((cfg_blk_log2 > 6) ? 6 : int'(cfg_blk_log2));
        s     = (cfg_set_log2 > 6) ? 6 : int'(cfg_set_log2);
        bsize = 1 << b;
        off   = int'(addr) & (bsize - 1);
        set   = (int'(addr) >> b) & ((1 << s) - 1);
        tag   = int'(addr) >> (b + s);
        base  = int'(addr) - off;

        // Scan from way 0: a free way ends it as a miss, a tag match as a hit.
        free_way = -1;
        hit_way  = -1;
        for (int i = 0; i < ways; i++) begin
            if (!line_vld[set][i]) begin
                free_way = i;
                break;
            end
            if (line_tg[set][i] == tag) begin
                hit_way = i;
                break;
            end
        end

        ld  = 64'd0;
        way = hit_way;
        hit = (hit_way >= 0);

        if (!hit && (op == OP_LOAD || mode_wb == MODE_WB)) begin
            if (free_way >= 0) begin
                way = free_way;
            end else begin
                vic = 0;
                for (int i = 1; i < ways; i++)
                    if (lru_pos[set][i] > lru_pos[set][vic]) vic = i;
                way = vic;
                // A dirty victim always goes back to memory, whatever the mode.
                if (line_drt[set][vic]) begin
                    wb_base = (line_tg[set][vic] << (b + s)) | (set << b);
                    for (int i = 0; i < bsize; i++)
                        mem_bytes[(wb_base + i) & 16'hFFFF] = line_data[set][vic][i];
                end
            end
            for (int i = 0; i < bsize; i++)
                line_data[set][way][i] = mem_bytes[(base + i) & 16'hFFFF];
            line_tg[set][way]  = tag;
            line_vld[set][way] = 1'b1;
            line_drt[set][way] = 1'b0;
        end

        if (way >= 0) begin
            for (int i = 0; i < n; i++) begin
                o = (off + i) & (bsize - 1);
                if (op == OP_STORE) begin
                    byte_v = 8'(sd >> (8 * (n - 1 - i)));
                    line_data[set][way][o] = byte_v;
                    if (mode_wb == MODE_WT) mem_bytes[(base + o) & 16'hFFFF] = byte_v;
                end else begin
                    ld = {ld[55:0], line_data[set][way][o]};
                end
            end
            if (op == OP_STORE && mode_wb == MODE_WB) line_drt[set][way] = 1'b1;
            r = lru_pos[set][way];
            for (int k = 0; k < 8; k++)
                if (lru_pos[set][k] < r) lru_pos[set][k]++;
            lru_pos[set][way] = 0;
        end else begin
            // Write-through store miss: memory is written and nothing is allocated.
            for (int i = 0; i < n; i++) begin
                o = (off + i) & (bsize - 1);
                mem_bytes[(base + o) & 16'hFFFF] = 8'(sd >> (8 * (n - 1 - i)));
            end
        end
        if (op == OP_STORE) ld = 64'd0;
    endfunction

    // ------------------------------------------------------------------
    // Register writes. These are only issued while no access is in flight, so
    // the model takes the new value at once.
    // ------------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input logic [3:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_WRITE_BACK: mode_wb      = val[0];
            CFG_WAYS:       cfg_ways     = val;
            CFG_BLOCK_LOG2: cfg_blk_log2 = val[2:0];
            CFG_SET_LOG2:   cfg_set_log2 = val[2:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic wb, input logic [3:0] ways,
                                input logic [3:0] blk, input logic [3:0] sets);
        write_reg(CFG_WRITE_BACK, {3'b000, wb});
        write_reg(CFG_WAYS, ways);
        write_reg(CFG_BLOCK_LOG2, blk);
        write_reg(CFG_SET_LOG2, sets);
    endtask

    // ------------------------------------------------------------------
    // Request side. valid stays high from one transfer to the next when no
    // gap follows, so it is never lowered and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_access(input logic op, input logic [15:0] addr, input logic [3:0] nb,
                               input logic [63:0] sd, input logic fixed,
                               input logic fx_hit, input logic [63:0] fx_data);
        t_result res;
        in_if.valid        <= 1'b1;
        in_if.operation    <= op;
        in_if.address      <= addr;
        in_if.access_bytes <= nb;
        in_if.store_data   <= sd;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_access(op, addr, nb, sd, res.hit, res.load_data);
        // Rows whose outcome is plain from the access itself carry it typed in.
        if (fixed) begin
            res.hit       = fx_hit;
            res.load_data = fx_data;
        end
        expected_q.push_back(res);
        n_accepted++;
        if (op == OP_STORE) n_stores++;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        // Nothing here is result-free, but allow the longest access to settle anyway.
        repeat (30) @(posedge i_clk);
    endtask

    // Random accesses. Most fall in twelve 256-byte windows 4 KiB apart, where
    // like offsets share a set in every geometry, so sets fill, hit and evict;
    // the rest span the whole memory. Any length occurs, including 0 and above 8.
    task automatic random_accesses(input int count);
        logic        op;
        logic [15:0] addr;
        logic [3:0]  nb;
        logic [63:0] sd;
        for (int i = 0; i < count; i++) begin
            op = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0)
                addr = 16'($urandom_range(0, 11) * 4096 + $urandom_range(0, 255));
            else
                addr = 16'($urandom);
            nb = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
            sd = {$urandom, $urandom};
            send_access(op, addr, nb, sd, 1'b0, 1'b0, 64'd0);
        end
    endtask

    // Directed accesses, walked in order at the maximum geometry.
    typedef struct {
        logic        op;
        logic [15:0] addr;
        logic [3:0]  nb;
        logic [63:0] sd;
        logic        fixed;
        logic        hit;
        logic [63:0] data;
    } t_row;

    t_row directed_rows [] = '{
        '{OP_LOAD,  16'h0000, 4'd8,  64'd0,                  1'b1, 1'b0, 64'd0},
        '{OP_LOAD,  16'hFFFF, 4'd1,  64'd0,                  1'b1, 1'b0, 64'd0},
        '{OP_LOAD,  16'h0000, 4'd8,  64'd0,                  1'b1, 1'b1, 64'd0},
        '{OP_STORE, 16'h0000, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'd0},
        '{OP_LOAD,  16'h0000, 4'd8,  64'd0,                  1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{OP_STORE, 16'h1003, 4'd4,  64'h0000_0000_A5A5_5A5A, 1'b1, 1'b0, 64'd0},
        '{OP_LOAD,  16'h1001, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h003C, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h0000, 4'd0,  64'd0,                  1'b1, 1'b1, 64'd0},
        '{OP_LOAD,  16'h0008, 4'd15, 64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_STORE, 16'hFFF8, 4'd8,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h2000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h3000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h4000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h5000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h6000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h7000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h8000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h9000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'h0000, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0},
        '{OP_LOAD,  16'hFFF8, 4'd8,  64'd0,                  1'b0, 1'b0, 64'd0}
    };

    // ------------------------------------------------------------------
    // Result side: ready idles in random bursts, and on request holds off
    // for a long stretch so that the cache fills and stalls its input.
    // ------------------------------------------------------------------
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                out_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: hit %0b load_data %h", out_if.hit, out_if.load_data);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                n_checked++;
                if (out_if.hit) n_hits++;
                if (out_if.hit !== exp_r.hit) begin
                    $error("hit: expected %0b, actual %0b", exp_r.hit, out_if.hit);
                    errors++;
                end
                if (out_if.load_data !== exp_r.load_data) begin
                    $error("load_data: expected %h, actual %h",
                           exp_r.load_data, out_if.load_data);
                    errors++;
                end
            end
        end
    end

    // Watchdog over the whole run, allowing for the clearing pass.
    int cycle_count;
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("set_assoc_cache_lru_wb_wt regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence. Block size never grows during the run, so every valid
    // line has all of its bytes filled under the geometry it is read with.
    // ------------------------------------------------------------------
    initial begin
        errors        = 0;
        n_accepted    = 0;
        n_checked     = 0;
        n_hits        = 0;
        n_stores      = 0;
        sink_idle_en  = 1'b1;
        sink_hold_req = 1'b0;
        src_idle_en   = 1'b1;

        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.operation     <= OP_LOAD;
        in_if.address       <= '0;
        in_if.access_bytes  <= '0;
        in_if.store_data    <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= CFG_WRITE_BACK;
        cfg_if.data         <= '0;
        cache_model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out-of-range values saturate to eight ways, 64-byte blocks, 64 sets.
        // Register writes are taken during the clearing pass.
        set_geometry(MODE_WB, 4'd15, 4'd7, 4'd7);
        foreach (directed_rows[i])
            send_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].nb,
                        directed_rows[i].sd, directed_rows[i].fixed,
                        directed_rows[i].hit, directed_rows[i].data);
        random_accesses(40);
        drain();

        // Write-through at full geometry, with a long hold-off on results.
        set_geometry(MODE_WT, 4'd8, 4'd6, 4'd6);
        random_accesses(20);
        sink_hold_req = 1'b1;
        random_accesses(50);
        drain();

        // Direct-mapped, one set, 32-byte blocks.
        set_geometry(MODE_WB, 4'd1, 4'd5, 4'd0);
        random_accesses(70);
        drain();

        // Three ways, four sets, 16-byte blocks; the sender pauses part way.
        set_geometry(MODE_WT, 4'd3, 4'd4, 4'd2);
        random_accesses(35);
        drain();
        random_accesses(35);
        drain();

        // Zero ways saturates to one; smallest block.
        set_geometry(MODE_WB, 4'd0, 4'd3, 4'd6);
        random_accesses(40);
        drain();

        // Final stretch at full speed on both sides; block size 2 saturates to 8 bytes.
        set_geometry(MODE_WB, 4'd2, 4'd2, 4'd1);
        sink_idle_en = 1'b0;
        src_idle_en  = 1'b0;
        random_accesses(60);
        drain();

        $display("covered %0d accesses (%0d stores, %0d hits) over six geometries",
                 n_accepted, n_stores, n_hits);
        $display("in write-back and write-through modes; %0d results checked", n_checked);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("set_assoc_cache_lru_wb_wt regression: pass");
        end else begin
            $display("set_assoc_cache_lru_wb_wt regression: fail");
        end
        $finish;
    end

endmodule

@@ set_assoc_cache_lru_wb_wt.f @@
rtl/sacl_pkg.sv
rtl/sacl_if.sv
rtl/sacl_lookup.sv
rtl/set_assoc_cache_lru_wb_wt.sv
tb/tb_set_assoc_cache_lru_wb_wt.sv
